// ===== rtl/gls_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, codes, reset values and table entry types for the galloping
// level search core. No dependencies.
package gls_pkg;

    // Field widths
    localparam int LEVEL_W     = 9;
    localparam int COUNT_W     = 10;
    localparam int ENTRY_CNT_W = 11;
    localparam int MAXLEV_W    = 9;
    localparam int PIVOT_W     = 10;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 10;

    // Default table size and register reset values
    localparam int                    MAX_LEVELS_DEF = 256;
    localparam logic [MAXLEV_W-1:0]   MAX_LEVELS_RST = 9'd256;
    localparam logic [PIVOT_W-1:0]    PIVOT_RST      = 10'd46;

    // Cell count saturation
    localparam logic [COUNT_W-1:0]     CELL_MAX      = 10'd1023;
    localparam logic [ENTRY_CNT_W-1:0] CELL_MAX_WIDE = 11'd1023;
    localparam logic [COUNT_W-1:0]     CELL_FALLBACK = 10'd1;
    localparam logic [ENTRY_CNT_W-1:0] TOP_COUNT     = 11'd1;

    // Input command codes
    localparam logic CMD_BEGIN  = 1'b0;
    localparam logic CMD_RESULT = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVELS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PIVOT      = 1'd1;

    // One table entry: saturated flag and recorded count
    typedef struct packed {
        logic                   sat;
        logic [ENTRY_CNT_W-1:0] count;
    } t_entry;

    // Table read word: known mark plus entry
    typedef struct packed {
        logic   known;
        t_entry entry;
    } t_rd;

endpackage

// ===== rtl/gls_ifs.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the galloping level search core:
// input items, result items and configuration writes. Uses gls_pkg.
interface gls_in_if;
    logic                         valid;
    logic                         ready;
    logic                         command;
    logic                         first_round;
    logic                         below;
    logic [gls_pkg::COUNT_W-1:0]  solution_count;

    modport source (output valid, command, first_round, below, solution_count,
                    input ready);
    modport sink   (input valid, command, first_round, below, solution_count,
                    output ready);
endinterface

interface gls_out_if;
    logic                         valid;
    logic                         ready;
    logic                         done_res;
    logic [gls_pkg::LEVEL_W-1:0]  level;
    logic [gls_pkg::COUNT_W-1:0]  cell_count;

    modport source (output valid, done_res, level, cell_count, input ready);
    modport sink   (input valid, done_res, level, cell_count, output ready);
endinterface

interface gls_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [gls_pkg::CFG_IDX_W-1:0]   index;
    logic [gls_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/gls_table.sv =====
`timescale 1ns / 1ps
// Per-level table: synchronous memory of saturated flag and count, two
// registered read ports, one write port, flop known marks cleared at once.
// Uses gls_pkg types.
module gls_table #(
    parameter int MAX_LEVELS = gls_pkg::MAX_LEVELS_DEF,
    parameter int LW         = $clog2(MAX_LEVELS + 2)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_rd_en,
    input  logic [LW-1:0]          i_rd_a_addr,
    input  logic [LW-1:0]          i_rd_b_addr,
    output gls_pkg::t_rd           o_rd_a,
    output gls_pkg::t_rd           o_rd_b,
    input  logic                   i_clr,
    input  logic                   i_wr_en,
    input  logic [LW-1:0]          i_wr_addr,
    input  gls_pkg::t_entry        i_wr_data
);
    localparam int DEPTH = MAX_LEVELS + 1;
    localparam int AW    = $clog2(DEPTH);

    gls_pkg::t_entry  r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [DEPTH-1:0] n_valid;
    logic             w_a_in;
    logic             w_b_in;
    logic             w_wr_in;
    logic [AW-1:0]    w_a_idx;
    logic [AW-1:0]    w_b_idx;
    logic [AW-1:0]    w_wr_idx;
    logic             r_a_known;
    logic             r_b_known;
    gls_pkg::t_entry  r_a_data;
    gls_pkg::t_entry  r_b_data;

    // Range checks; out-of-table addresses read as unknown
    assign w_a_in   = (32'(i_rd_a_addr) <= MAX_LEVELS);
    assign w_b_in   = (32'(i_rd_b_addr) <= MAX_LEVELS);
    assign w_wr_in  = (32'(i_wr_addr)   <= MAX_LEVELS);
    assign w_a_idx  = w_a_in  ? i_rd_a_addr[AW-1:0] : '0;
    assign w_b_idx  = w_b_in  ? i_rd_b_addr[AW-1:0] : '0;
    assign w_wr_idx = i_wr_addr[AW-1:0];

    // Clear all known marks on begin, then mark the written entry
    always_comb begin
        n_valid = i_clr ? '0 : r_valid;
        if (i_wr_en && w_wr_in) begin
            n_valid[w_wr_idx] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Memory write port and registered read ports
    always_ff @(posedge i_clk) begin
        if (i_wr_en && w_wr_in) begin
            r_mem[w_wr_idx] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_a_data  <= r_mem[w_a_idx];
            r_b_data  <= r_mem[w_b_idx];
            r_a_known <= w_a_in && r_valid[w_a_idx];
            r_b_known <= w_b_in && r_valid[w_b_idx];
        end
    end

    assign o_rd_a = '{known: r_a_known, entry: r_a_data};
    assign o_rd_b = '{known: r_b_known, entry: r_b_data};

endmodule

// ===== rtl/galloping_level_search_core.sv =====
`timescale 1ns / 1ps
// Top level of the galloping level search core: sequencer state, handshakes,
// configuration registers. Depends on gls_pkg, gls_ifs and gls_table.
//
//  Port    | Dir | Word                                        | Accepted when
//  --------+-----+---------------------------------------------+------------------
//  i_cfg   | in  | index, data (max_levels or pivot)           | valid (ready = 1)
//  i_in    | in  | command, first_round, below, solution_count | valid && ready
//  o_out   | out | done_res, level, cell_count                 | valid && ready
//
// On accept the table reads are issued; once the step may proceed it is evaluated
// from the registered read data, writes the table and loads the result register.
// A new word is taken once the step is done, also while a result still waits;
// the step stalls only while the result register is full and not taken.
// Synchronous active-low reset clears control state and all known marks;
// a begin word clears all known marks at once, with no clearing pass.
module galloping_level_search_core #(
    parameter int MAX_LEVELS = gls_pkg::MAX_LEVELS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gls_cfg_if.sink   i_cfg,
    gls_in_if.sink    i_in,
    gls_out_if.source o_out
);
    localparam int LW      = $clog2(MAX_LEVELS + 2);
    localparam int SW      = LW + 3;
    localparam int LEVEL_W = gls_pkg::LEVEL_W;
    localparam logic signed [SW-1:0] S_ONE = SW'(1);
    localparam logic signed [SW-1:0] S_TWO = SW'(2);

    // Configuration registers
    logic [gls_pkg::MAXLEV_W-1:0]    r_max_levels;
    logic [gls_pkg::PIVOT_W-1:0]     r_pivot;

    // Search state
    logic [LW-1:0] r_low,  n_low;
    logic [LW-1:0] r_high, n_high;
    logic [LW-1:0] r_cur,  n_cur;
    logic [LW-1:0] r_prev, n_prev;
    logic [LW-1:0] r_last, n_last;
    logic          r_later, n_later;
    logic          r_busy,  n_busy;

    // Held input word
    logic                         r_pend;
    logic                         r_cmd;
    logic                         r_first;
    logic                         r_below;
    logic [gls_pkg::COUNT_W-1:0]  r_count;

    // Result register
    logic                         r_out_valid;
    logic                         r_out_done;
    logic [LEVEL_W-1:0]           r_out_level;
    logic [gls_pkg::COUNT_W-1:0]  r_out_cell;

    // Step signals
    logic                         w_acc;
    logic                         w_fire;
    logic [LW-1:0]                w_m;
    logic [LW-1:0]                w_addr_a;
    gls_pkg::t_rd                 w_rd_a;
    gls_pkg::t_rd                 w_rd_b;
    logic                         w_clr;
    logic                         w_we;
    logic [LW-1:0]                w_waddr;
    gls_pkg::t_entry              w_wdata;
    logic                         w_done;
    logic [LW-1:0]                w_lvl;
    logic [gls_pkg::COUNT_W-1:0]  w_cell;
    logic [gls_pkg::ENTRY_CNT_W-1:0] w_sat_cnt;
    logic [LW-1:0]                w_lw;

    logic signed [SW-1:0] s_h, s_low, s_high, s_prev, s_last;
    logic signed [SW-1:0] s_d, s_nxt, s_lo_n, s_p, s_two;

    function automatic logic [gls_pkg::COUNT_W-1:0] cap_cell(
        input logic [gls_pkg::ENTRY_CNT_W-1:0] c
    );
        logic [gls_pkg::COUNT_W-1:0] v;
        v = (c > gls_pkg::CELL_MAX_WIDE) ? gls_pkg::CELL_MAX
                                         : c[gls_pkg::COUNT_W-1:0];
        return v;
    endfunction

    // Handshakes
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_pend;
    assign w_acc       = i_in.valid && !r_pend;
    assign w_fire      = r_pend && (!r_out_valid || o_out.ready);

    assign o_out.valid      = r_out_valid;
    assign o_out.done_res   = r_out_done;
    assign o_out.level      = r_out_level;
    assign o_out.cell_count = r_out_cell;

    // Effective level limit: zero reads as one, clamp to table size
    always_comb begin
        w_m = LW'(MAX_LEVELS);
        if (r_max_levels == '0) begin
            w_m = LW'(1);
        end else if (32'(r_max_levels) < MAX_LEVELS) begin
            w_m = LW'(r_max_levels);
        end
    end

    // Neighbor read: below level on a below word, above level otherwise
    assign w_addr_a  = i_in.below ? (r_cur - LW'(1)) : (r_cur + LW'(1));
    assign w_sat_cnt = gls_pkg::ENTRY_CNT_W'(r_pivot) + gls_pkg::ENTRY_CNT_W'(1);
    assign w_lw      = r_first ? '0 : r_last;

    // Table updates only on a completed step
    gls_table #(
        .MAX_LEVELS (MAX_LEVELS),
        .LW         (LW)
    ) u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (w_acc),
        .i_rd_a_addr (w_addr_a),
        .i_rd_b_addr (r_high),
        .o_rd_a      (w_rd_a),
        .o_rd_b      (w_rd_b),
        .i_clr       (w_clr && w_fire),
        .i_wr_en     (w_we && w_fire),
        .i_wr_addr   (w_waddr),
        .i_wr_data   (w_wdata)
    );

    // Evaluate one step of the search
    always_comb begin
        n_low   = r_low;
        n_high  = r_high;
        n_cur   = r_cur;
        n_prev  = r_prev;
        n_last  = r_last;
        n_later = r_later;
        n_busy  = r_busy;
        w_clr   = 1'b0;
        w_we    = 1'b0;
        w_waddr = r_cur;
        w_wdata = '{sat: 1'b0, count: gls_pkg::ENTRY_CNT_W'(r_count)};
        w_done  = 1'b0;
        w_lvl   = r_cur;
        w_cell  = '0;

        s_h    = SW'(r_cur);
        s_low  = SW'(r_low);
        s_high = SW'(r_high);
        s_prev = SW'(r_prev);
        s_last = SW'(r_last);
        s_d    = s_h - s_last;
        if (s_d < 0) begin
            s_d = -s_d;
        end
        s_nxt  = s_h;
        s_lo_n = s_low;
        s_p    = s_prev;
        s_two  = s_low + ((s_h - s_low) <<< 1);

        if (r_cmd == gls_pkg::CMD_BEGIN) begin
            // Start a measurement: clear marks, seed the top entry
            n_later = !r_first;
            n_last  = w_lw;
            w_clr   = 1'b1;
            w_we    = 1'b1;
            w_waddr = w_m;
            w_wdata = '{sat: 1'b0, count: gls_pkg::TOP_COUNT};
            n_low   = '0;
            n_high  = w_m;
            n_cur   = w_lw;
            n_prev  = w_lw;
            n_busy  = 1'b1;
            w_lvl   = w_lw;
        end else if (r_busy) begin
            if (r_below) begin
                if (r_cur == '0 || (w_rd_a.known && w_rd_a.entry.sat)) begin
                    // Level zero, or level below saturates: this level wins
                    n_last = r_cur;
                    n_busy = 1'b0;
                    w_done = 1'b1;
                    w_cell = r_count;
                end else begin
                    w_we   = 1'b1;
                    n_high = r_cur;
                    if (r_later && s_d <= S_TWO) begin
                        s_nxt = s_h - S_ONE;
                    end else begin
                        if (s_p > s_h) begin
                            s_p = '0;
                        end
                        if (s_p > s_low) begin
                            s_lo_n = s_p;
                        end
                        s_nxt = (s_h + s_lo_n) >>> 1;
                    end
                    n_low  = LW'(s_lo_n);
                    n_prev = r_cur;
                    n_cur  = (s_nxt < 0) ? '0 : LW'(s_nxt);
                    w_lvl  = n_cur;
                    if (s_low >= s_h) begin
                        // Exploration exhausted: fall back to the high bracket
                        n_last = r_cur;
                        n_cur  = r_cur;
                        n_busy = 1'b0;
                        w_done = 1'b1;
                        w_lvl  = r_cur;
                        w_cell = r_count;
                    end
                end
            end else begin
                if (w_rd_a.known && !w_rd_a.entry.sat) begin
                    // Level above is below pivot: it wins
                    n_last = r_cur + LW'(1);
                    n_cur  = r_cur + LW'(1);
                    n_busy = 1'b0;
                    w_done = 1'b1;
                    w_lvl  = r_cur + LW'(1);
                    w_cell = cap_cell(w_rd_a.entry.count);
                end else begin
                    w_we    = 1'b1;
                    w_wdata = '{sat: 1'b1, count: w_sat_cnt};
                    if (r_later && s_d < S_TWO) begin
                        s_lo_n = s_h;
                        s_nxt  = s_h + S_ONE;
                    end else if (s_two >= s_high - S_ONE) begin
                        s_lo_n = s_h;
                        s_nxt  = (s_h + s_high) >>> 1;
                    end else begin
                        s_nxt = s_two;
                        if (s_nxt == s_h) begin
                            s_nxt = s_h + S_ONE;
                        end
                    end
                    n_low  = LW'(s_lo_n);
                    n_prev = r_cur;
                    n_cur  = (s_nxt < 0) ? '0 : LW'(s_nxt);
                    w_lvl  = n_cur;
                    if (s_h >= s_high) begin
                        // Exploration exhausted: fall back to the high bracket
                        n_last = r_high;
                        n_cur  = r_high;
                        n_busy = 1'b0;
                        w_done = 1'b1;
                        w_lvl  = r_high;
                        if (r_high == r_cur) begin
                            w_cell = cap_cell(w_sat_cnt);
                        end else if (w_rd_b.known) begin
                            w_cell = cap_cell(w_rd_b.entry.count);
                        end else begin
                            w_cell = gls_pkg::CELL_FALLBACK;
                        end
                    end
                end
            end
        end
    end

    // Control state, configuration and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_levels <= gls_pkg::MAX_LEVELS_RST;
            r_pivot      <= gls_pkg::PIVOT_RST;
            r_low        <= '0;
            r_high       <= '0;
            r_cur        <= '0;
            r_prev       <= '0;
            r_last       <= '0;
            r_later      <= 1'b0;
            r_busy       <= 1'b0;
            r_pend       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            // Take configuration writes
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    gls_pkg::REG_MAX_LEVELS: begin
                        r_max_levels <= i_cfg.data[gls_pkg::MAXLEV_W-1:0];
                    end
                    gls_pkg::REG_PIVOT: begin
                        r_pivot <= i_cfg.data;
                    end
                    default: begin
                    end
                endcase
            end
            // Hold a word from accept until its step completes
            if (w_acc) begin
                r_pend <= 1'b1;
            end else if (w_fire) begin
                r_pend <= 1'b0;
            end
            // Advance search state on a completed step
            if (w_fire) begin
                r_low   <= n_low;
                r_high  <= n_high;
                r_cur   <= n_cur;
                r_prev  <= n_prev;
                r_last  <= n_last;
                r_later <= n_later;
                r_busy  <= n_busy;
            end
            // Result register: load on step, drop when taken
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_cmd   <= i_in.command;
            r_first <= i_in.first_round;
            r_below <= i_in.below;
            r_count <= i_in.solution_count;
        end
        if (w_fire) begin
            r_out_done  <= w_done;
            r_out_level <= LEVEL_W'(w_lvl);
            r_out_cell  <= w_cell;
        end
    end

    // Table read and write never fall in the same cycle
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_acc && w_fire))
        else $error("table read and write overlap");

    // High bracket stays inside the table
    a_high_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_high <= LW'(MAX_LEVELS))
        else $error("high bracket beyond table");

    // A winning result ends the measurement
    a_done_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_done) |=> !r_busy)
        else $error("measurement still running after winner");

    // High bracket entry is always recorded when a saturated word is evaluated
    a_high_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_busy && r_cmd == gls_pkg::CMD_RESULT && !r_below)
        |-> w_rd_b.known)
        else $error("high bracket entry not recorded");

endmodule
